// ===== sv/itrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Idle-timeout residency table package
// Shared types, operation and result codes, and default constants.
// ----------------------------------------------------------------------------
package itrt_pkg;

   localparam int unsigned TABLE_DEPTH_DEFAULT = 32;
   localparam logic [31:0] IDLE_LIMIT_RESET    = 32'd20;

   // Operation codes of an input item.
   localparam logic [1:0] OP_ACCESS = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Result kinds.
   localparam logic [2:0] KIND_UNLOAD = 3'd0;
   localparam logic [2:0] KIND_LOAD   = 3'd1;
   localparam logic [2:0] KIND_HIT    = 3'd2;
   localparam logic [2:0] KIND_MISS   = 3'd3;
   localparam logic [2:0] KIND_FULL   = 3'd4;
   localparam logic [2:0] KIND_DONE   = 3'd5;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] asset_id;
      logic        auto_load;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] asset_id_res;
      logic        last;
   } rsp_type;

   // Contents of one table slot.
   typedef struct packed {
      logic        valid;
      logic [31:0] id;
      logic [31:0] stamp;
   } entry_type;

   // Commands from the controller to every cell.
   typedef struct packed {
      logic stamp_en;
      logic insert_en;
      logic rotate;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DONE
   } state_type;

endpackage

// ===== sv/itrt_cell.sv =====
// ----------------------------------------------------------------------------
// Residency table cell
// Holds one slot; compares against the looked-up id and shifts to its neighbor.
// ----------------------------------------------------------------------------
module itrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  itrt_pkg::cell_ctl_type ctl,
   input  logic [31:0]           lookup_id,
   input  logic [31:0]           tick,
   input  logic                  free_in,
   input  itrt_pkg::entry_type   neighbor,
   output itrt_pkg::entry_type   entry,
   output logic                  hit,
   output logic                  free_out
);

   logic        valid_ff, valid_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] stamp_ff, stamp_in;

   assign hit      = valid_ff && (id_ff == lookup_id);
   // Free-slot claim ripples from the lowest slot upward.
   assign free_out = free_in || !valid_ff;

   assign entry.valid = valid_ff;
   assign entry.id    = id_ff;
   assign entry.stamp = stamp_ff;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      stamp_in = stamp_ff;
      if (ctl.rotate) begin
         valid_in = neighbor.valid;
         id_in    = neighbor.id;
         stamp_in = neighbor.stamp;
      end else if (ctl.stamp_en && hit) begin
         stamp_in = tick;
      end else if (ctl.insert_en && !valid_ff && !free_in) begin
         valid_in = 1'b1;
         id_in    = lookup_id;
         stamp_in = tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff    <= id_in;
      stamp_ff <= stamp_in;
   end

endmodule

// ===== sv/itrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Residency table controller
// Accepts items, steers the cell row, runs sweeps and holds the result register.
// ----------------------------------------------------------------------------
module itrt_ctrl #(
   parameter int unsigned TABLE_DEPTH = itrt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  itrt_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output itrt_pkg::rsp_type      rsp_data,
   input  logic                   csr_wr_en,
   input  logic [31:0]            csr_wr_data,
   input  logic                   any_hit,
   input  logic                   any_free,
   input  itrt_pkg::entry_type    head,
   output itrt_pkg::cell_ctl_type ctl,
   output logic                   evict_head,
   output logic [31:0]            tick
);

   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_DEPTH - 1);

   itrt_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   itrt_pkg::rsp_type   rsp_ff, rsp_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                clear_ff, clear_in;
   logic [31:0]         tick_ff, tick_in;
   logic [31:0]         limit_ff;
   logic                out_free;
   logic [31:0]         head_age;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign head_age  = tick_ff - head.stamp;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign tick      = tick_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cnt_in       = cnt_ff;
      clear_in     = clear_ff;
      tick_in      = tick_ff;
      ctl          = '0;
      evict_head   = 1'b0;
      req_stall    = 1'b1;
      unique case (state_ff)
         itrt_pkg::ST_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               unique case (req_data.operation)
                  itrt_pkg::OP_ACCESS: begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.asset_id_res = req_data.asset_id;
                     rsp_in.last         = 1'b1;
                     ctl.stamp_en        = 1'b1;
                     ctl.insert_en       = !any_hit && req_data.auto_load;
                     if (any_hit) begin
                        rsp_in.kind = itrt_pkg::KIND_HIT;
                     end else if (!req_data.auto_load) begin
                        rsp_in.kind = itrt_pkg::KIND_MISS;
                     end else if (!any_free) begin
                        rsp_in.kind = itrt_pkg::KIND_FULL;
                     end else begin
                        rsp_in.kind = itrt_pkg::KIND_LOAD;
                     end
                  end
                  itrt_pkg::OP_TICK, itrt_pkg::OP_CLEAR: begin
                     clear_in = (req_data.operation == itrt_pkg::OP_CLEAR);
                     cnt_in   = '0;
                     state_in = itrt_pkg::ST_SWEEP;
                  end
                  default: begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.kind         = itrt_pkg::KIND_DONE;
                     rsp_in.asset_id_res = '0;
                     rsp_in.last         = 1'b1;
                  end
               endcase
            end
         end
         itrt_pkg::ST_SWEEP: begin
            if (out_free) begin
               // The ring turns one slot; the head slot is judged on its way past.
               ctl.rotate = 1'b1;
               evict_head = head.valid && (clear_ff || (head_age > limit_ff));
               if (evict_head) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.kind         = itrt_pkg::KIND_UNLOAD;
                  rsp_in.asset_id_res = head.id;
                  rsp_in.last         = 1'b0;
               end
               if (cnt_ff == CNT_LAST) begin
                  state_in = itrt_pkg::ST_DONE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         itrt_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.kind         = itrt_pkg::KIND_DONE;
               rsp_in.asset_id_res = '0;
               rsp_in.last         = 1'b1;
               tick_in             = tick_ff + 32'd1;
               state_in            = itrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itrt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itrt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         limit_ff     <= itrt_pkg::IDLE_LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_ff      <= tick_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
      rsp_ff   <= rsp_in;
      cnt_ff   <= cnt_in;
      clear_ff <= clear_in;
   end

`ifndef SYNTH
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != itrt_pkg::ST_IDLE |-> req_stall)
      else $error("input taken while a sweep is running");

   a_sweep_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itrt_pkg::ST_SWEEP && !out_free) |=> $stable(cnt_ff))
      else $error("sweep advanced while result register was blocked");

   a_done_emitted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itrt_pkg::ST_DONE && out_free)
      |=> (rsp_valid_ff && rsp_ff.kind == itrt_pkg::KIND_DONE && rsp_ff.last))
      else $error("sweep ended without a done result");

   a_unload_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == itrt_pkg::KIND_UNLOAD) |-> !rsp_ff.last)
      else $error("unload result marked last");
`endif

endmodule

// ===== sv/idle_timeout_residency_table_top.sv =====
// An access item's single result is registered in the cycle after acceptance.
// A tick or clear item turns the cell ring once, slot by slot, in the sweep
// state, then registers its done result in the done state; rsp stalls hold both.
// Throughput: one access per cycle unless rsp stalls; a sweep blocks new items
// until its done item. Reset (synchronous, active high) empties the table,
// zeroes the tick counter, sets idle_limit to 20; slot ids, stamps not cleared.
// ----------------------------------------------------------------------------
// Idle-timeout residency table, top level
// A row of slot cells driven by one controller with a registered result.
// ----------------------------------------------------------------------------
module idle_timeout_residency_table_top #(
   parameter int unsigned TABLE_DEPTH = itrt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  itrt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output itrt_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

   itrt_pkg::entry_type    entries [TABLE_DEPTH];
   itrt_pkg::entry_type    tail_entry;
   logic [TABLE_DEPTH-1:0] hit_vec;
   logic [TABLE_DEPTH:0]   free_chain;
   itrt_pkg::cell_ctl_type ctl;
   logic                   evict_head;
   logic [31:0]            tick;

   // Free-slot priority starts at slot zero with nothing claimed below it.
   assign free_chain[0] = 1'b0;

   // During a sweep the head slot wraps to the tail, freed if it was evicted.
   assign tail_entry.valid = entries[0].valid && !evict_head;
   assign tail_entry.id    = entries[0].id;
   assign tail_entry.stamp = entries[0].stamp;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      itrt_pkg::entry_type neighbor;
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign neighbor = tail_entry;
      end else begin : g_mid
         assign neighbor = entries[i + 1];
      end
      itrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .lookup_id (req_data.asset_id),
         .tick      (tick),
         .free_in   (free_chain[i]),
         .neighbor  (neighbor),
         .entry     (entries[i]),
         .hit       (hit_vec[i]),
         .free_out  (free_chain[i + 1])
      );
   end

   // The controller sees one hit flag, one free flag and the head slot.
   itrt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .any_hit     (|hit_vec),
      .any_free    (free_chain[TABLE_DEPTH]),
      .head        (entries[0]),
      .ctl         (ctl),
      .evict_head  (evict_head),
      .tick        (tick)
   );

endmodule

// ===== sim/itrt_result_checker.sv =====
// ----------------------------------------------------------------------------
// Residency table result checker
// Watches the req, rsp and csr ports of the residency table. It keeps its own
// copy of the table, the tick counter and the idle limit, and works out the
// results of every accepted item. Each accepted result is compared against
// the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module itrt_result_checker #(
   parameter int unsigned TABLE_DEPTH = itrt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  itrt_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  itrt_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   output int unsigned       results_owed,
   output int unsigned       mismatch_count
);
   import itrt_pkg::*;

   localparam int unsigned REPORT_LIMIT = 40;

   logic        slot_used  [TABLE_DEPTH];
   logic [31:0] slot_id    [TABLE_DEPTH];
   logic [31:0] slot_stamp [TABLE_DEPTH];
   logic [31:0] tick_now;
   logic [31:0] idle_limit;
   rsp_type     owed_rsp_q [$];
   rsp_type     oldest_rsp;
   int unsigned fail_total = 0;

   function automatic rsp_type make_rsp(logic [2:0] kind, logic [31:0] id, logic last);
      rsp_type r;
      r.kind         = kind;
      r.asset_id_res = id;
      r.last         = last;
      return r;
   endfunction

   // Applies one item to the shadow table and queues the results it causes.
   function automatic void apply_table_item(req_type item);
      int          free_slot;
      bit          found;
      logic [31:0] age;
      free_slot = -1;
      found     = 1'b0;
      case (item.operation)
         OP_ACCESS: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (!found && slot_used[i] && slot_id[i] == item.asset_id) begin
                  slot_stamp[i] = tick_now;
                  found         = 1'b1;
               end
               if (!slot_used[i] && free_slot < 0)
                  free_slot = i;
            end
            if (found)
               owed_rsp_q.push_back(make_rsp(KIND_HIT, item.asset_id, 1'b1));
            else if (!item.auto_load)
               owed_rsp_q.push_back(make_rsp(KIND_MISS, item.asset_id, 1'b1));
            else if (free_slot < 0)
               owed_rsp_q.push_back(make_rsp(KIND_FULL, item.asset_id, 1'b1));
            else begin
               slot_used[free_slot]  = 1'b1;
               slot_id[free_slot]    = item.asset_id;
               slot_stamp[free_slot] = tick_now;
               owed_rsp_q.push_back(make_rsp(KIND_LOAD, item.asset_id, 1'b1));
            end
         end
         OP_TICK, OP_CLEAR: begin
            // Slots are swept in ascending order; the age wraps at 32 bits.
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               age = tick_now - slot_stamp[i];
               if (slot_used[i] && (item.operation == OP_CLEAR || age > idle_limit)) begin
                  owed_rsp_q.push_back(make_rsp(KIND_UNLOAD, slot_id[i], 1'b0));
                  slot_used[i] = 1'b0;
               end
            end
            tick_now = tick_now + 32'd1;
            owed_rsp_q.push_back(make_rsp(KIND_DONE, 32'd0, 1'b1));
         end
         default: begin
            owed_rsp_q.push_back(make_rsp(KIND_DONE, 32'd0, 1'b1));
         end
      endcase
   endfunction

   function automatic void report(string field, logic [31:0] want, logic [31:0] got);
      if (fail_total < REPORT_LIMIT)
         $display("%0t: rsp %s mismatch, expected %h, actual %h", $time, field, want, got);
      fail_total++;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++)
            slot_used[i] = 1'b0;
         tick_now   = 32'd0;
         idle_limit = IDLE_LIMIT_RESET;
         owed_rsp_q.delete();
      end else begin
         if (csr_wr_en)
            idle_limit = csr_wr_data;
         if (req_valid && !req_stall)
            apply_table_item(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (owed_rsp_q.size() == 0) begin
               if (fail_total < REPORT_LIMIT)
                  $display("%0t: unexpected rsp item, expected none, actual kind %0d id %h last %0d",
                           $time, rsp_data.kind, rsp_data.asset_id_res, rsp_data.last);
               fail_total++;
            end else begin
               oldest_rsp = owed_rsp_q.pop_front();
               if (rsp_data.kind !== oldest_rsp.kind)
                  report("kind", 32'(oldest_rsp.kind), 32'(rsp_data.kind));
               if (rsp_data.asset_id_res !== oldest_rsp.asset_id_res)
                  report("asset_id_res", oldest_rsp.asset_id_res, rsp_data.asset_id_res);
               if (rsp_data.last !== oldest_rsp.last)
                  report("last", 32'(oldest_rsp.last), 32'(rsp_data.last));
            end
         end
      end
      results_owed   <= owed_rsp_q.size();
      mismatch_count <= fail_total;
   end

endmodule

// ===== sim/idle_timeout_residency_table_top_test.sv =====
// ----------------------------------------------------------------------------
// Residency table testbench
// Drives access, tick, clear and unused items into the residency table with
// random gaps on the sender and random stalls on the receiver, moves the idle
// limit between phases, and leaves all checking to the result checker.
// ----------------------------------------------------------------------------
module idle_timeout_residency_table_top_test;
   import itrt_pkg::*;

   localparam int unsigned TABLE_DEPTH   = TABLE_DEPTH_DEFAULT;
   // The operation code that the block does not use; it only gives a done item.
   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   // Cycles without any accepted item before the run is declared hung. The
   // longest legal quiet stretch is the receiver hold-off below.
   localparam int unsigned QUIET_LIMIT   = 4000;
   localparam int unsigned HOLD_CYCLES   = 300;
   // Longer than a sweep with no rsp stalls, so this covers any late result.
   localparam int unsigned DRAIN_CYCLES  = TABLE_DEPTH + 8;
   localparam int unsigned PHASE_ITEMS   = 24;
   localparam int unsigned BURST_ITEMS   = TABLE_DEPTH + 8;
   localparam int unsigned POOL_SIZE     = 24;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;

   int unsigned results_owed;
   int unsigned mismatch_count;

   // Idling percentages for the current phase, and the hold-off handshake
   // between the stimulus process and the receiver process. The run starts
   // with the sender idling less than the receiver.
   int unsigned tx_gap_pct    = 33;
   int unsigned rx_stall_pct  = 48;
   int unsigned hold_requests = 0;
   int unsigned hold_served   = 0;
   int unsigned hold_left     = 0;
   int unsigned quiet_cycles  = 0;

   // A small pool of ids makes hits and re-loads common in the random part.
   logic [31:0] id_pool [POOL_SIZE];

   idle_timeout_residency_table_top #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   itrt_result_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) rsp_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .results_owed   (results_owed),
      .mismatch_count (mismatch_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver stalls at random, except during a requested hold-off, when
   // it stalls without a break for HOLD_CYCLES, so the block backs up into req.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES - 1;
         rsp_stall   <= 1'b1;
      end else
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
   end

   // Watchdog: any accepted item or register write restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         quiet_cycles <= 0;
      else if (quiet_cycles == QUIET_LIMIT - 1) begin
         $display("tb: failure");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   function automatic req_type access(logic [31:0] id, logic load);
      req_type item;
      item.operation = OP_ACCESS;
      item.asset_id  = id;
      item.auto_load = load;
      return item;
   endfunction

   // Tick, clear and unused items ignore the id and load bit; those carry
   // random filler so the fields still toggle.
   function automatic req_type control(logic [1:0] op);
      req_type item;
      item.operation = op;
      item.asset_id  = $urandom();
      item.auto_load = 1'($urandom_range(1));
      return item;
   endfunction

   // Mostly accesses to pooled ids, with enough ticks to age entries out and
   // the odd clear, unused operation or fully random id.
   function automatic req_type random_item();
      req_type     item;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 72) begin
         if ($urandom_range(9) == 0)
            item = access($urandom(), $urandom_range(3) != 0);
         else
            item = access(id_pool[$urandom_range(POOL_SIZE - 1)], $urandom_range(3) != 0);
      end else if (roll < 92)
         item = control(OP_TICK);
      else if (roll < 97)
         item = control(OP_CLEAR);
      else
         item = control(OP_UNUSED);
      return item;
   endfunction

   // Offers one item and holds it until it is taken. Valid stays high into
   // the next item unless a gap is drawn, so it is never dropped and raised
   // in the same step.
   task automatic offer(req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   // Waits until every expected result has come back, then waits out
   // DRAIN_CYCLES before the block is considered idle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_idle_limit(logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_phase(int unsigned count);
      for (int n = 0; n < count; n++)
         offer(random_item());
   endtask

   initial begin
      for (int i = 0; i < POOL_SIZE; i++)
         id_pool[i] = $urandom();
      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset idle limit. A miss without load, a
      // load, a hit, the id extremes, the unused operation, a tick that
      // evicts nothing, a clear of three entries and a clear of an empty
      // table.
      offer(access(32'h0000_0000, 1'b0));
      offer(access(32'h0000_0000, 1'b1));
      offer(access(32'h0000_0000, 1'b0));
      offer(access(32'hFFFF_FFFF, 1'b1));
      offer(access(32'hA5A5_5A5A, 1'b1));
      offer(access(32'h5A5A_A5A5, 1'b0));
      offer(control(OP_UNUSED));
      offer(control(OP_TICK));
      offer(control(OP_CLEAR));
      offer(control(OP_CLEAR));
      wait_drained();

      // With a limit of one, a restamped entry survives a tick that evicts
      // its older neighbor, then ages out itself one tick later.
      write_idle_limit(32'd1);
      offer(access(32'h0000_0011, 1'b1));
      offer(access(32'h0000_0022, 1'b1));
      offer(control(OP_TICK));
      offer(access(32'h0000_0011, 1'b0));
      offer(control(OP_TICK));
      offer(control(OP_TICK));
      offer(access(32'h0000_0022, 1'b0));
      offer(control(OP_TICK));
      wait_drained();

      // Limit zero: every tick evicts all entries not used since the last
      // tick. The sender idles often and the receiver more so.
      write_idle_limit(32'd0);
      tx_gap_pct   <= 33;
      rx_stall_pct <= 48;
      random_phase(PHASE_ITEMS);
      wait_drained();

      // Largest limit: nothing ever ages out, only clears free entries.
      // The idling roles are swapped.
      write_idle_limit(32'hFFFF_FFFF);
      tx_gap_pct   <= 48;
      rx_stall_pct <= 33;
      random_phase(PHASE_ITEMS);
      wait_drained();

      // No idling. After a clear, the receiver holds off for a long stretch
      // while a burst of fresh ids is offered back to back: the block backs
      // up, and the burst overruns the table so the last ids come back full.
      write_idle_limit(32'd3);
      tx_gap_pct   <= 0;
      rx_stall_pct <= 0;
      offer(control(OP_CLEAR));
      hold_requests <= hold_requests + 1;
      for (int n = 0; n < BURST_ITEMS; n++)
         offer(access($urandom(), 1'b1));
      random_phase(PHASE_ITEMS);
      wait_drained();

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
